>>> design/bli_pkg.sv
package bli_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // Fixed field widths of the request and response
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CntOutW = 5;

  // Internal widths derived from the capacity
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_RM_FRONT  = 3'd2,
    CMD_RM_BACK   = 3'd3,
    CMD_RM_AT     = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  // Keep the low DATA_WIDTH bits of a request value (zero-filled above 32)
  function automatic data_t to_data(input logic [ValW-1:0] v);
    logic [63:0] tmp;
    tmp = 64'(v);
    return tmp[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word and cut it to the response width
  function automatic logic [ValW-1:0] from_data(input data_t d);
    logic signed [DATA_WIDTH-1:0] s;
    logic [63:0] tmp;
    s   = signed'(d);
    tmp = 64'(s);
    return tmp[ValW-1:0];
  endfunction

endpackage

>>> design/bli_req_if.sv
interface bli_req_if
  import bli_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic signed [ValW-1:0] value;
  logic [PosW-1:0]        position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

>>> design/bli_rsp_if.sv
interface bli_rsp_if
  import bli_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] removed_value;
  logic [StatW-1:0]       status;
  logic [CntOutW-1:0]     count_after;

  modport source (output valid, removed_value, status, count_after, input ready);
  modport sink   (input valid, removed_value, status, count_after, output ready);
endinterface

>>> design/bounded_list_insert_remove.sv
// Bounded ordered list of CAPACITY signed words, positions 0 to count-1.
// Request channel (req_i): command, value, position. Commands insert at
// the front or back, remove the front or back, or remove at a position.
// Response channel (rsp_o): removed_value (zero if nothing removed),
// status (ok, empty, bad position, full) and count_after.
// One response per request, in order.
// The response is registered and shows up in the cycle after the
// request is taken. Throughput: one request per cycle unless stalled;
// every cell of the chain shifts in parallel in the same cycle.
// Stall: while a response waits and rsp_o.ready is low, req_i.ready is
// low; a response taken in the same cycle frees room for the next request.
// Reset (rst_ni low, asynchronous): count goes to zero and the response
// register empties. Stored words are not cleared; only positions below
// count are ever read.
module bounded_list_insert_remove
  import bli_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bli_req_if.sink    req_i,
  bli_rsp_if.source  rsp_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rsp_valid_q;
  logic [ValW-1:0] rm_val_q, rm_val_d;
  status_e         status_q, status_d;
  logic [CntW-1:0] cnt_out_q;

  logic            accept;
  logic            full, empty;
  logic            do_ins_front, do_ins_back, do_rm;
  logic [CntW-1:0] rm_idx;
  data_t           ins_data;

  data_t           elem [CAPACITY];
  cell_op_e        op   [CAPACITY];

  // Output register may refill whenever it is empty or being drained
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full     = (cnt_q == CntW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign ins_data = to_data(req_i.value);

  // Command decode
  always_comb begin
    do_ins_front = 1'b0;
    do_ins_back  = 1'b0;
    do_rm        = 1'b0;
    rm_idx       = '0;
    status_d     = ST_OK;
    cnt_d        = cnt_q;
    case (cmd_e'(req_i.command))
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins_front = (cmd_e'(req_i.command) == CMD_INS_FRONT);
          do_ins_back  = (cmd_e'(req_i.command) == CMD_INS_BACK);
          cnt_d        = cnt_q + CntW'(1);
        end
      end
      CMD_RM_FRONT, CMD_RM_BACK, CMD_RM_AT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (cmd_e'(req_i.command) == CMD_RM_FRONT) begin
          do_rm = 1'b1;
          rm_idx = '0;
        end else if (cmd_e'(req_i.command) == CMD_RM_BACK) begin
          do_rm = 1'b1;
          rm_idx = cnt_q - CntW'(1);
        end else if (CmpW'(req_i.position) >= CmpW'(cnt_q)) begin
          status_d = ST_BAD_POS;
        end else begin
          do_rm = 1'b1;
          rm_idx = CntW'(req_i.position);
        end
        if (do_rm) begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  // Word leaving the list; rm_idx is below count whenever it is used
  always_comb begin
    rm_val_d = '0;
    if (do_rm) begin
      rm_val_d = from_data(elem[rm_idx[IdxW-1:0]]);
    end
  end

  // Per-cell shift control and the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      op[i] = CELL_HOLD;
      if (accept) begin
        if (do_ins_front) begin
          op[i] = (i == 0) ? CELL_LOAD : CELL_LEFT;
        end else if (do_ins_back && (cnt_q == CntW'(i))) begin
          op[i] = CELL_LOAD;
        end else if (do_rm && (CntW'(i) >= rm_idx)) begin
          op[i] = CELL_RIGHT;
        end
      end
    end

    bli_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op[i]),
      .ins_i   (ins_data),
      .left_i  ((i == 0) ? ins_data : elem[(i == 0) ? 0 : i - 1]),
      .right_i ((i == CAPACITY - 1) ? elem[i] : elem[(i == CAPACITY - 1) ? i : i + 1]),
      .data_o  (elem[i])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rm_val_q  <= rm_val_d;
      status_q  <= status_d;
      cnt_out_q <= cnt_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.removed_value = rm_val_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.count_after   = CntOutW'(cnt_out_q);

endmodule

>>> design/bli_cell.sv
module bli_cell
  import bli_pkg::*;
(
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  data_t    ins_i,
  input  data_t    left_i,
  input  data_t    right_i,
  output data_t    data_o
);

  data_t data_q;
  data_t data_d;

  always_comb begin
    case (op_i)
      CELL_LOAD:  data_d = ins_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bli_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Values that hit the sign boundary and the all-zero / all-one patterns
  localparam logic [ValW-1:0] EDGE_VALUES [9] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0001, 32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555
  };

  // One response as the list should produce it
  typedef struct packed {
    logic [ValW-1:0]    removed;
    status_e            status;
    logic [CntOutW-1:0] count;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bli_req_if req_if ();
  bli_rsp_if rsp_if ();

  bounded_list_insert_remove dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the list, front at index 0
  data_t        stored_q [$];
  list_result_t expected_q [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  logic         idling_on;
  int unsigned  stall_left = 0;

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int unsigned idle_length();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Apply one request to the shadow list and return the response it owes.
  // Removed words are sign-extended from the stored width to the port width.
  function automatic list_result_t apply_command(input logic [CmdW-1:0] cmd,
                                                 input logic [ValW-1:0] val,
                                                 input logic [PosW-1:0] pos);
    list_result_t r;
    r.removed = '0;
    r.status  = ST_OK;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (stored_q.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_INS_FRONT) begin
          stored_q.push_front(DATA_WIDTH'(val));
        end else begin
          stored_q.push_back(DATA_WIDTH'(val));
        end
      end
      CMD_RM_FRONT, CMD_RM_BACK, CMD_RM_AT: begin
        // empty check wins over the position check
        if (stored_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (cmd == CMD_RM_FRONT) begin
          r.removed = ValW'($signed(stored_q.pop_front()));
        end else if (cmd == CMD_RM_BACK) begin
          r.removed = ValW'($signed(stored_q.pop_back()));
        end else if (pos >= stored_q.size()) begin
          r.status = ST_BAD_POS;
        end else begin
          r.removed = ValW'($signed(stored_q[pos]));
          stored_q.delete(pos);
        end
      end
      default: ; // unused codes leave the list alone
    endcase
    r.count = CntOutW'(stored_q.size());
    return r;
  endfunction

  // Drive one request and hold it until taken. Called at a rising edge.
  // valid stays high across back-to-back requests; it only drops for a gap.
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [ValW-1:0] val,
                              input logic [PosW-1:0] pos);
    int unsigned gap;
    gap = idle_length();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.value    <= val;
    req_if.position <= pos;
    do @(posedge clk_i); while (!req_if.ready);
    // the request was taken at this edge; its response comes later
    expected_q.push_back(apply_command(cmd, val, pos));
  endtask

  // One random request. insert_pct steers the fill level so the list
  // swings between empty and full over a run.
  task automatic send_random_request(input int unsigned insert_pct);
    logic [CmdW-1:0] cmd;
    logic [ValW-1:0] val;
    logic [PosW-1:0] pos;
    if ($urandom_range(99) < 3) begin
      cmd = CmdW'($urandom_range((1 << CmdW) - 1, int'(CMD_RM_AT) + 1));
    end else if ($urandom_range(99) < insert_pct) begin
      cmd = $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK;
    end else begin
      cmd = CmdW'($urandom_range(int'(CMD_RM_AT), int'(CMD_RM_FRONT)));
    end
    if ($urandom_range(99) < 10) begin
      val = EDGE_VALUES[$urandom_range(8)];
    end else begin
      val = $urandom;
    end
    // mostly a live position, sometimes anything the field holds
    if (stored_q.size() != 0 && $urandom_range(99) < 80) begin
      pos = PosW'($urandom_range(stored_q.size() - 1));
    end else begin
      pos = PosW'($urandom);
    end
    send_request(cmd, val, pos);
  endtask

  // Single-element removal, then every remove and an unused code on empty.
  task automatic test_single_and_empty();
    send_request(CMD_INS_BACK, 32'h7FFF_FFFF, '0);
    send_request(CMD_RM_AT, '0, '0);
    send_request(CMD_RM_FRONT, '0, '0);
    send_request(CMD_RM_BACK, '0, '0);
    send_request(CMD_RM_AT, '0, '1);
    send_request(CmdW'(int'(CMD_RM_AT) + 1), 32'h8000_0000, '1);
  endtask

  // Fill to capacity, the first nine with edge values, refuse inserts at
  // both ends, then remove the last slot and hit position equal to count.
  task automatic test_full_store();
    logic [ValW-1:0] val;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      val = (i < 9) ? EDGE_VALUES[i] : $urandom;
      send_request(i[0] ? CMD_INS_BACK : CMD_INS_FRONT, val, '0);
    end
    send_request(CMD_INS_FRONT, 32'h1234_5678, '0);
    send_request(CMD_INS_BACK, 32'h8765_4321, '0);
    send_request(CMD_RM_AT, '0, PosW'(CAPACITY - 1));
    send_request(CMD_RM_AT, '0, PosW'(CAPACITY - 1));
    send_request(CMD_RM_FRONT, '0, '0);
    send_request(CMD_RM_BACK, '0, '0);
  endtask

  // Random traffic in rounds, each round leaning toward inserts, removes
  // or neither.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      send_random_request(insert_pct);
    end
  endtask

  // Full rate on both sides: no gaps, no stalls.
  task automatic test_back_to_back(input int unsigned n_items);
    idling_on <= 1'b0;
    test_random_traffic(n_items);
    idling_on <= 1'b1;
  endtask

  // Response side: ready drops for random stretches.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin : pick_stall
      int unsigned n;
      n = idle_length();
      if (n == 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b0;
        stall_left   <= n - 1;
      end
    end
  end

  // Every accepted response is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_responses
    list_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response: removed_value %h status %0d count_after %0d",
                 $time, rsp_if.removed_value, rsp_if.status, rsp_if.count_after);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (rsp_if.removed_value !== want.removed) begin
          $display("%0t: removed_value expected %h, got %h",
                   $time, want.removed, rsp_if.removed_value);
          error_count++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.count_after !== want.count) begin
          $display("%0t: count_after expected %0d, got %0d",
                   $time, want.count, rsp_if.count_after);
          error_count++;
        end
      end
    end
  end

  // Watchdog for a hung handshake or lost responses
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    idling_on       <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.command  <= CMD_INS_FRONT;
    req_if.value    <= '0;
    req_if.position <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_and_empty();
    test_full_store();
    test_random_traffic(880);
    test_back_to_back(220);

    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
